// ===== rtl/rbb_pkg.sv =====
package rbb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 15;

    localparam int CHANNELS  = 3;
    localparam int PIX_W     = 8;
    localparam int OPOS_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // quotient bits: the mean never exceeds one pixel value
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [3:0]           RADIUS_RST = 4'd1;
    localparam logic [CFG_DAT_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_DAT_W-1:0] HEIGHT_RST = 11'd480;

    // controller to datapath
    typedef struct packed {
        logic              load;      // take input beat, latch position
        logic              update;    // sums update, RAM writes, advance
        logic              div_step;  // one restoring division step
        logic [STEP_W-1:0] step;
        logic              out_load;  // move quotients to output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic produce;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/rbb_ram.sv =====
module rbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rbb_ctrl.sv =====
module rbb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  rbb_pkg::dp_sts_t   sts,
    output rbb_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_OUT} state_t;

    state_t                     state_reg, state_next;
    logic [rbb_pkg::STEP_W-1:0] step_reg, step_next;

    // next state and step count
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CALC;
            end
            S_CALC: begin
                step_next  = '0;
                state_next = sts.produce ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == rbb_pkg::STEP_W'(rbb_pkg::DIV_STEPS - 1)) state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // commands decoded from state
    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.update   = (state_reg == S_CALC);
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.step     = step_reg;
    assign cmd.out_load = (state_reg == S_OUT) && sts.out_free;

    a_load_then_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.update)
        else $error("accepted beat not followed by update");

    a_div_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && step_reg != rbb_pkg::STEP_W'(rbb_pkg::DIV_STEPS - 1))
        |=> (cmd.div_step && step_reg == $past(step_reg) + 1'b1))
        else $error("division step sequence broken");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update || cmd.div_step) |-> !s_tready)
        else $error("input ready while a pixel is in work");

endmodule

// ===== rtl/rbb_datapath.sv =====
module rbb_datapath #(
    parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = rbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbb_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic [rbb_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rbb_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  rbb_pkg::ctrl_cmd_t                  cmd,
    output rbb_pkg::dp_sts_t                    sts
);

    localparam int NCH      = rbb_pkg::CHANNELS;
    localparam int PW       = rbb_pkg::PIX_W;
    localparam int SPAN_MAX = 2 * MAX_RADIUS + 1;
    localparam int R_W      = $clog2(MAX_RADIUS + 1);
    localparam int SPAN_W   = $clog2(SPAN_MAX + 1);
    localparam int SM_W     = $clog2(SPAN_MAX);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WD_W     = $clog2(MAX_WIDTH + 1);
    localparam int HD_W     = $clog2(MAX_HEIGHT + 1);
    localparam int CS_W     = $clog2(255 * SPAN_MAX + 1);
    localparam int WS_W     = $clog2(255 * SPAN_MAX * SPAN_MAX + 1);
    localparam int CNT_W    = $clog2(SPAN_MAX * SPAN_MAX + 1);
    localparam int DV_W     = WS_W + rbb_pkg::DIV_STEPS;
    localparam int RS_DEPTH = SPAN_MAX * (1 << COL_W);

    // configuration registers
    logic [3:0]                    radius_reg;
    logic [rbb_pkg::CFG_DAT_W-1:0] width_reg, height_reg;
    logic                          restart;

    assign restart = cfg_valid && (cfg_index == rbb_pkg::REG_RADIUS ||
                                   cfg_index == rbb_pkg::REG_WIDTH  ||
                                   cfg_index == rbb_pkg::REG_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= rbb_pkg::RADIUS_RST;
            width_reg  <= rbb_pkg::WIDTH_RST;
            height_reg <= rbb_pkg::HEIGHT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == rbb_pkg::REG_RADIUS) radius_reg <= cfg_data[3:0];
            if (cfg_index == rbb_pkg::REG_WIDTH)  width_reg  <= cfg_data;
            if (cfg_index == rbb_pkg::REG_HEIGHT) height_reg <= cfg_data;
        end
    end

    // clamped geometry
    logic [R_W-1:0]    rad;
    logic [SPAN_W-1:0] span;
    logic [WD_W-1:0]   w_eff;
    logic [HD_W-1:0]   h_eff;
    logic [CNT_W-1:0]  count_reg;

    always_comb begin
        rad  = (32'(radius_reg) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_reg);
        span = SPAN_W'({rad, 1'b1});
        if (width_reg == '0)                  w_eff = WD_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)  w_eff = WD_W'(MAX_WIDTH);
        else                                  w_eff = WD_W'(width_reg);
        if (height_reg == '0)                 h_eff = HD_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT) h_eff = HD_W'(MAX_HEIGHT);
        else                                  h_eff = HD_W'(height_reg);
    end

    // window pixel count, small multiply registered
    always_ff @(posedge aclk) begin
        count_reg <= CNT_W'(span) * CNT_W'(span);
    end

    // raster position and its residues modulo span
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [SM_W-1:0]  rmod_reg, cmod_reg;
    logic             wrap;
    logic [ROW_W-1:0] e_row;
    logic [COL_W-1:0] e_col;
    logic [SM_W-1:0]  e_rmod, e_cmod;

    assign wrap   = (WD_W'(col_reg) >= w_eff) || (HD_W'(row_reg) >= h_eff);
    assign e_row  = wrap ? '0 : row_reg;
    assign e_col  = wrap ? '0 : col_reg;
    assign e_rmod = wrap ? '0 : rmod_reg;
    assign e_cmod = wrap ? '0 : cmod_reg;

    // memories
    logic [NCH*CS_W-1:0] csum_rd, wcol_rd, cs_flat;
    logic [NCH*PW-1:0]   rs_rd;
    logic [NCH*PW-1:0]   pix_reg;

    rbb_ram #(.WIDTH(NCH*CS_W), .DEPTH(1 << COL_W)) u_csum (
        .aclk(aclk), .we(cmd.update), .waddr(e_col), .wdata(cs_flat),
        .raddr(e_col), .rdata(csum_rd)
    );

    rbb_ram #(.WIDTH(NCH*PW), .DEPTH(RS_DEPTH)) u_rows (
        .aclk(aclk), .we(cmd.update), .waddr($clog2(RS_DEPTH)'({e_rmod, e_col})),
        .wdata(pix_reg), .raddr($clog2(RS_DEPTH)'({e_rmod, e_col})), .rdata(rs_rd)
    );

    rbb_ram #(.WIDTH(NCH*CS_W), .DEPTH(SPAN_MAX)) u_wcol (
        .aclk(aclk), .we(cmd.update), .waddr(e_cmod), .wdata(cs_flat),
        .raddr(e_cmod), .rdata(wcol_rd)
    );

    // column and window sums
    logic [NCH-1:0][WS_W-1:0] ws_reg, ws_new;
    logic                     produce, last;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            logic [CS_W-1:0] p, cs;
            p = CS_W'(pix_reg[c*PW +: PW]);
            if (row_reg == '0)
                cs = p;
            else if ((ROW_W+1)'(row_reg) < (ROW_W+1)'(span))
                cs = csum_rd[c*CS_W +: CS_W] + p;
            else
                cs = csum_rd[c*CS_W +: CS_W] + p - CS_W'(rs_rd[c*PW +: PW]);
            cs_flat[c*CS_W +: CS_W] = cs;
            if (col_reg == '0)
                ws_new[c] = WS_W'(cs);
            else if ((COL_W+1)'(col_reg) < (COL_W+1)'(span))
                ws_new[c] = ws_reg[c] + WS_W'(cs);
            else
                ws_new[c] = ws_reg[c] + WS_W'(cs) - WS_W'(wcol_rd[c*CS_W +: CS_W]);
        end
        produce = ((ROW_W+1)'(row_reg) >= (ROW_W+1)'(2 * rad)) &&
                  ((COL_W+1)'(col_reg) >= (COL_W+1)'(2 * rad));
        last    = (HD_W'(row_reg) == h_eff - 1'b1) && (WD_W'(col_reg) == w_eff - 1'b1);
    end

    // position advance
    logic             col_end, row_end, cmod_end, rmod_end;
    assign col_end  = (WD_W'(col_reg) + 1'b1 >= w_eff);
    assign row_end  = (HD_W'(row_reg) + 1'b1 >= h_eff);
    assign cmod_end = (SPAN_W'(cmod_reg) + 1'b1 == span);
    assign rmod_end = (SPAN_W'(rmod_reg) + 1'b1 == span);

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            row_reg  <= '0;
            col_reg  <= '0;
            rmod_reg <= '0;
            cmod_reg <= '0;
        end else if (cmd.load) begin
            row_reg  <= e_row;
            col_reg  <= e_col;
            rmod_reg <= e_rmod;
            cmod_reg <= e_cmod;
        end else if (cmd.update) begin
            if (col_end) begin
                col_reg  <= '0;
                cmod_reg <= '0;
                if (row_end) begin
                    row_reg  <= '0;
                    rmod_reg <= '0;
                end else begin
                    row_reg  <= row_reg + 1'b1;
                    rmod_reg <= rmod_end ? '0 : rmod_reg + 1'b1;
                end
            end else begin
                col_reg  <= col_reg + 1'b1;
                cmod_reg <= cmod_end ? '0 : cmod_reg + 1'b1;
            end
        end
    end

    // pixel latch, window sum, restoring divider
    localparam int OPOS_W_L = rbb_pkg::OPOS_W;

    logic [NCH-1:0][WS_W-1:0] rem_reg;
    logic [NCH-1:0][PW-1:0]   quo_reg;
    logic [OPOS_W_L-1:0]      orow_reg, ocol_reg;
    logic                     olast_reg;
    logic [DV_W-1:0]          dsh;

    assign dsh = DV_W'(count_reg) << (rbb_pkg::STEP_W'(rbb_pkg::DIV_STEPS - 1) - cmd.step);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_reg <= s_tdata;
        end
        if (cmd.update) begin
            ws_reg <= ws_new;
            if (produce) begin
                rem_reg   <= ws_new;
                quo_reg   <= '0;
                orow_reg  <= OPOS_W_L'(row_reg - ROW_W'(rad));
                ocol_reg  <= OPOS_W_L'(col_reg - COL_W'(rad));
                olast_reg <= last;
            end
        end
        if (cmd.div_step) begin
            for (int c = 0; c < NCH; c++) begin
                if (DV_W'(rem_reg[c]) >= dsh) begin
                    rem_reg[c] <= WS_W'(DV_W'(rem_reg[c]) - dsh);
                    quo_reg[c] <= {quo_reg[c][PW-2:0], 1'b1};
                end else begin
                    quo_reg[c] <= {quo_reg[c][PW-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    logic                            m_tvalid_reg;
    logic [rbb_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                            m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= rbb_pkg::OUT_TDATA_W'({ocol_reg, orow_reg,
                                                  quo_reg[2], quo_reg[1], quo_reg[0]});
            m_tlast_reg <= olast_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tlast      = m_tlast_reg;
    assign sts.produce  = produce;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

// ===== rtl/rgb_box_blur_core.sv =====
// RGB box blur, floor mean over a (2r+1)x(2r+1) window, interior pixels only.
// Pixel without a result: accept (read), then update, then ready again.
// Pixel with a result: accept, update, the 8-step restoring divider, then output load.
// Result appears on m_ from the output register, loaded once the output is free.
// Synchronous active-low reset: radius 1, 640x480, position row 0 col 0.
// No memory clearing after reset; a radius, width or height write restarts the frame.
module rgb_box_blur_core #(
    parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = rbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbb_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic [rbb_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], out_row[33:24],
    // out_col[43:34], zero pad[47:44]
    output logic [rbb_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    rbb_pkg::ctrl_cmd_t cmd;
    rbb_pkg::dp_sts_t   sts;

    assign cfg_ready = 1'b1;

    rbb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    rbb_datapath #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tdata(s_tdata), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cmd(cmd), .sts(sts)
    );

endmodule

// ===== bench/rgb_box_blur_core_tb.sv =====
`timescale 1ns / 100ps

module rgb_box_blur_core_tb;

    localparam int MAX_W  = rbb_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H  = rbb_pkg::DEF_MAX_HEIGHT;
    localparam int MAX_R  = rbb_pkg::DEF_MAX_RADIUS;
    localparam int NCH    = rbb_pkg::CHANNELS;
    localparam int SPAN_M = 2 * MAX_R + 1;
    localparam logic [rbb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_MAX  = 18;
    localparam int SETTLE_CYC = 24;
    localparam int WDOG_LIMIT = 3000;

    typedef struct packed {
        logic       last;
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } blur_result_t;

    // running-sum model of the blur and queue of means still to arrive
    class blur_scoreboard;
        int unsigned  radius, width, height;
        int unsigned  col_sum[MAX_W][NCH];
        int unsigned  row_mem[SPAN_M * MAX_W][NCH];
        int unsigned  win_col[SPAN_M][NCH];
        int unsigned  win_sum[NCH];
        int unsigned  row_pos, col_pos;
        blur_result_t mean_q[$];
        int           errors;
        int           pixels_seen;
        int           means_seen;
        int           last_seen;

        function new();
            radius = 32'(rbb_pkg::RADIUS_RST);
            width  = 32'(rbb_pkg::WIDTH_RST);
            height = 32'(rbb_pkg::HEIGHT_RST);
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (col_sum[i, c]) col_sum[i][c] = 0;
            foreach (win_col[i, c]) win_col[i][c] = 0;
            foreach (win_sum[c]) win_sum[c] = 0;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void write_reg(logic [rbb_pkg::CFG_IDX_W-1:0] idx,
                                logic [rbb_pkg::CFG_DAT_W-1:0] val);
            case (idx)
                rbb_pkg::REG_RADIUS: radius = 32'(val & 11'hF);
                rbb_pkg::REG_WIDTH:  width  = 32'(val);
                rbb_pkg::REG_HEIGHT: height = 32'(val);
                default:             return;
            endcase
            restart_frame();
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned mx);
            if (v == 0) return 1;
            return (v > mx) ? mx : v;
        endfunction

        function int pending();
            return mean_q.size();
        endfunction

        // accepted input pixel: update sums, queue the mean if interior
        function void note_pixel(logic [rbb_pkg::IN_TDATA_W-1:0] d);
            int unsigned  r, span, w, h, row, col, rslot, cslot, cs, cnt;
            int unsigned  pix[NCH];
            blur_result_t res;
            r    = (radius > MAX_R) ? MAX_R : radius;
            span = 2 * r + 1;
            w    = clamp(width, MAX_W);
            h    = clamp(height, MAX_H);
            row  = row_pos;
            col  = col_pos;
            if (col >= w || row >= h) begin
                row = 0;
                col = 0;
            end
            pix[0] = 32'(d[7:0]);
            pix[1] = 32'(d[15:8]);
            pix[2] = 32'(d[23:16]);
            rslot  = (row % span) * MAX_W + col;
            cslot  = col % span;
            pixels_seen++;
            for (int ch = 0; ch < NCH; ch++) begin
                if (row == 0)
                    cs = pix[ch];
                else if (row < span)
                    cs = col_sum[col][ch] + pix[ch];
                else
                    cs = col_sum[col][ch] + pix[ch] - row_mem[rslot][ch];
                col_sum[col][ch]   = cs;
                row_mem[rslot][ch] = pix[ch];
                if (col == 0)
                    win_sum[ch] = cs;
                else if (col < span)
                    win_sum[ch] += cs;
                else
                    win_sum[ch] = win_sum[ch] + cs - win_col[cslot][ch];
                win_col[cslot][ch] = cs;
            end
            if (row + 1 >= span && col + 1 >= span) begin
                cnt       = span * span;
                res.red   = 8'(win_sum[0] / cnt);
                res.green = 8'(win_sum[1] / cnt);
                res.blue  = 8'(win_sum[2] / cnt);
                res.row   = 10'(row - r);
                res.col   = 10'(col - r);
                res.last  = (row == h - 1 && col == w - 1);
                mean_q.insert(mean_q.size(), res);
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
            row_pos = row;
            col_pos = col;
        endfunction

        function void field_cmp(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        // accepted output beat against the oldest queued mean
        function void check_beat(logic [rbb_pkg::OUT_TDATA_W-1:0] d, logic tlast);
            blur_result_t e;
            means_seen++;
            if (tlast) last_seen++;
            if (mean_q.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %h last %b",
                         $time, d, tlast);
                errors++;
                return;
            end
            e = mean_q[0];
            mean_q.delete(0);
            field_cmp("red_out",    32'(e.red),   32'(d[7:0]));
            field_cmp("green_out",  32'(e.green), 32'(d[15:8]));
            field_cmp("blue_out",   32'(e.blue),  32'(d[23:16]));
            field_cmp("out_row",    32'(e.row),   32'(d[33:24]));
            field_cmp("out_col",    32'(e.col),   32'(d[43:34]));
            field_cmp("pad",        0,            32'(d[47:44]));
            field_cmp("frame_last", 32'(e.last),  32'(tlast));
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [rbb_pkg::CFG_DAT_W-1:0]     cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [rbb_pkg::IN_TDATA_W-1:0]    s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [rbb_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                              m_tlast;

    blur_scoreboard sb;
    int  wdog;
    int  random_pixels;
    int  phases;
    bit  rx_no_stall;

    rgb_box_blur_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // check every accepted output beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
    end

    // output side: random stall before each beat, keep ready high when none
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = rx_no_stall ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // watchdog: cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d means outstanding",
                     wdog, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // register write, only with the block drained
    task automatic write_cfg(logic [rbb_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbb_pkg::CFG_DAT_W-1:0] val);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [rbb_pkg::IN_TDATA_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return rbb_pkg::IN_TDATA_W'($urandom());
        endcase
    endfunction

    // send n pixels (random content unless a list is given) with random gaps unless no_gap
    task automatic send_pixels(int n, bit no_gap,
                               logic [rbb_pkg::IN_TDATA_W-1:0] px[$] = {});
        int gap;
        for (int i = 0; i < n; i++) begin
            gap = no_gap ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= (i < px.size()) ? px[i] : rand_pixel();
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sb.note_pixel(s_tdata);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic set_frame(int unsigned r, int unsigned w, int unsigned h);
        write_cfg(rbb_pkg::REG_RADIUS, rbb_pkg::CFG_DAT_W'(r));
        write_cfg(rbb_pkg::REG_WIDTH, rbb_pkg::CFG_DAT_W'(w));
        write_cfg(rbb_pkg::REG_HEIGHT, rbb_pkg::CFG_DAT_W'(h));
    endtask

    initial begin
        int unsigned r, w, h, n;
        sb = new();
        wdog = 0;
        random_pixels = 0;
        phases = 0;
        rx_no_stall = 1'b0;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: a few pixels, no interior yet
        send_pixels(4, 1'b0, '{24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55});
        // zero sizes read as 1x1, radius 0: every pixel is a whole frame
        set_frame(0, 0, 0);
        send_pixels(4, 1'b1, '{24'hFFFFFF, 24'h000000, 24'h55AA55, 24'hAA55AA});
        // unused index must not restart the frame
        write_cfg(REG_UNUSED, 11'h7FF);
        send_pixels(2, 1'b0);
        // smallest window with an interior
        set_frame(1, 3, 3);
        send_pixels(9, 1'b0, '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                               24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE});
        // window larger than the frame
        set_frame(2, 3, 3);
        send_pixels(12, 1'b0);
        // oversize width and height saturate, radius upper data bits ignored
        set_frame(11'h7F0, 11'h7FF, 11'h7FF);
        send_pixels(60, 1'b1);
        // large radius, one full frame plus wrap into the next
        set_frame(13, 27, 27);
        send_pixels(27 * 27 + 2, 1'b0);

        // random frames, mostly small, mostly whole frames
        while (random_pixels < 130) begin
            phases++;
            rx_no_stall = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                r = $urandom_range(0, 2047);
                w = $urandom_range(0, 2047);
                h = $urandom_range(0, 4);
                n = $urandom_range(1, 80);
            end else begin
                r = $urandom_range(0, 3);
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
                n = (w * h * $urandom_range(2, 5)) / 2 + $urandom_range(0, 3);
                if (n > 80) n = 80;
            end
            case ($urandom_range(0, 3))
                0:       write_cfg(rbb_pkg::REG_WIDTH, rbb_pkg::CFG_DAT_W'(w));
                1:       write_cfg(rbb_pkg::REG_RADIUS, rbb_pkg::CFG_DAT_W'(r));
                default: set_frame(r, w, h);
            endcase
            send_pixels(n, $urandom_range(0, 3) == 0);
            random_pixels += n;
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        $display("covered %0d pixels in %0d random phases plus directed frames",
                 sb.pixels_seen, phases);
        $display("checked %0d window means, %0d frame ends", sb.means_seen, sb.last_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
